// ===== hdl/knn3_pkg.sv =====
// ----------------------------------------------------------------------------
// knn3_pkg
// Shared types and constants of the three-nearest-neighbor classifier.
// ----------------------------------------------------------------------------
package knn3_pkg;

  localparam int FEATURE_BITS = 16;
  localparam int CLASS_BITS   = 8;
  localparam int SQ_BITS      = 2 * FEATURE_BITS;
  localparam int DIST_BITS    = 41;
  localparam int NUM_SLOTS    = 3;

  typedef logic signed [FEATURE_BITS-1:0] feat_t;
  typedef logic [SQ_BITS-1:0]             sq_t;
  typedef logic [DIST_BITS-1:0]           dist_t;
  typedef logic [CLASS_BITS-1:0]          class_t;

  localparam dist_t DIST_MAX = '1;

  typedef struct packed {
    logic fire;
    logic eop;
    logic eos;
  } nbr_ctl_t;

  typedef struct packed {
    logic   known;
    class_t cls;
  } vote_t;

endpackage

// ===== hdl/knn3_sqdiff.sv =====
// ----------------------------------------------------------------------------
// knn3_sqdiff
// Squared difference of one query feature and one training feature.
// ----------------------------------------------------------------------------
module knn3_sqdiff
  import knn3_pkg::*;
(
  input  feat_t query_feature,
  input  feat_t train_feature,
  output sq_t   sq
);

  logic signed [FEATURE_BITS:0] diff;
  logic        [FEATURE_BITS:0] neg;
  logic        [FEATURE_BITS-1:0] mag;

  always_comb begin
    diff = $signed({query_feature[FEATURE_BITS-1], query_feature})
         - $signed({train_feature[FEATURE_BITS-1], train_feature});
    neg  = -diff;
    mag  = diff[FEATURE_BITS] ? neg[FEATURE_BITS-1:0] : diff[FEATURE_BITS-1:0];
    sq   = SQ_BITS'(mag) * SQ_BITS'(mag);
  end

endmodule

// ===== hdl/knn3_nbr.sv =====
// ----------------------------------------------------------------------------
// knn3_nbr
// Saturating distance accumulator, sorted three-slot neighbor list and vote.
// ----------------------------------------------------------------------------
module knn3_nbr
  import knn3_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  nbr_ctl_t ctl,
  input  sq_t      sq,
  input  class_t   cls,
  output vote_t    vote
);

  dist_t  sum_r;
  dist_t  dist_r [NUM_SLOTS];
  class_t cls_r  [NUM_SLOTS];
  logic   fill_r [NUM_SLOTS];

  logic [DIST_BITS:0] sum_ext;
  dist_t              sum_acc;
  logic               lt [NUM_SLOTS];
  dist_t              dist_ins [NUM_SLOTS];
  class_t             cls_ins  [NUM_SLOTS];
  logic               fill_ins [NUM_SLOTS];
  logic               m02;
  logic               m12;
  logic               pick1;
  logic               pick_fill;
  class_t             pick_cls;

  always_comb begin
    sum_ext = {1'b0, sum_r} + (DIST_BITS+1)'(sq);
    sum_acc = (sum_ext >= {1'b0, DIST_MAX}) ? DIST_MAX : sum_ext[DIST_BITS-1:0];
    for (int i = 0; i < NUM_SLOTS; i++) begin
      lt[i] = sum_acc < dist_r[i];
    end

    // insert at first strictly farther slot, shift the rest down
    if (lt[0]) begin
      dist_ins[0] = sum_acc; cls_ins[0] = cls;      fill_ins[0] = 1'b1;
    end else begin
      dist_ins[0] = dist_r[0]; cls_ins[0] = cls_r[0]; fill_ins[0] = fill_r[0];
    end
    if (lt[0]) begin
      dist_ins[1] = dist_r[0]; cls_ins[1] = cls_r[0]; fill_ins[1] = fill_r[0];
    end else if (lt[1]) begin
      dist_ins[1] = sum_acc; cls_ins[1] = cls;      fill_ins[1] = 1'b1;
    end else begin
      dist_ins[1] = dist_r[1]; cls_ins[1] = cls_r[1]; fill_ins[1] = fill_r[1];
    end
    if (lt[0] || lt[1]) begin
      dist_ins[2] = dist_r[1]; cls_ins[2] = cls_r[1]; fill_ins[2] = fill_r[1];
    end else if (lt[2]) begin
      dist_ins[2] = sum_acc; cls_ins[2] = cls;      fill_ins[2] = 1'b1;
    end else begin
      dist_ins[2] = dist_r[2]; cls_ins[2] = cls_r[2]; fill_ins[2] = fill_r[2];
    end

    m02 = (!fill_ins[0] && !fill_ins[2])
       || (fill_ins[0] && fill_ins[2] && (cls_ins[0] == cls_ins[2]));
    m12 = (!fill_ins[1] && !fill_ins[2])
       || (fill_ins[1] && fill_ins[2] && (cls_ins[1] == cls_ins[2]));
    pick1     = !m02 && m12;
    pick_fill = pick1 ? fill_ins[1] : fill_ins[0];
    pick_cls  = pick1 ? cls_ins[1]  : cls_ins[0];

    vote.known = pick_fill;
    vote.cls   = pick_fill ? pick_cls : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        dist_r[i] <= DIST_MAX;
        cls_r[i]  <= '0;
        fill_r[i] <= 1'b0;
      end
    end else if (ctl.fire) begin
      if (ctl.eos) begin
        // clear for the next query
        sum_r <= '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          dist_r[i] <= DIST_MAX;
          cls_r[i]  <= '0;
          fill_r[i] <= 1'b0;
        end
      end else if (ctl.eop) begin
        sum_r <= '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          dist_r[i] <= dist_ins[i];
          cls_r[i]  <= cls_ins[i];
          fill_r[i] <= fill_ins[i];
        end
      end else begin
        sum_r <= sum_acc;
      end
    end
  end

endmodule

// ===== hdl/knn3_euclidean_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// knn3_euclidean_classifier_unit
// Streamed three-nearest-neighbor classifier on squared Euclidean distance.
// ----------------------------------------------------------------------------
//  Channel | Ports                                          | Transaction
//  --------+------------------------------------------------+--------------------
//  in      | in_valid/in_stall, features, class, end flags  | one feature pair
//  out     | out_valid/out_stall, predicted_class, known    | one vote per set
//
//  One transaction per cycle while in_stall is low; the end-of-set transaction
//  passes the input register, square register and result register in order.
//  The saturating accumulate, neighbor insert and vote share one stage.
//  Reset clears the pipeline valids, the neighbor list and the result valid.
//  in_stall rises only while an end-of-set item waits behind a stalled result.
// ----------------------------------------------------------------------------
module knn3_euclidean_classifier_unit
  import knn3_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [FEATURE_BITS-1:0] in_query_feature,
  input  logic signed [FEATURE_BITS-1:0] in_train_feature,
  input  logic [CLASS_BITS-1:0]         in_point_class,
  input  logic                          in_end_of_point,
  input  logic                          in_end_of_set,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [CLASS_BITS-1:0]         out_predicted_class,
  output logic                          out_class_known
);

  logic   v1_r;
  feat_t  q1_r;
  feat_t  t1_r;
  class_t cls1_r;
  logic   eop1_r;
  logic   eos1_r;

  logic   v2_r;
  sq_t    sq2_r;
  class_t cls2_r;
  logic   eop2_r;
  logic   eos2_r;

  logic   out_valid_r;
  class_t out_cls_r;
  logic   out_known_r;

  sq_t      sq1;
  nbr_ctl_t ctl;
  vote_t    vote;
  logic     stall_last;
  logic     adv2;
  logic     en1;

  always_comb begin
    stall_last = v2_r && eos2_r && out_valid_r && out_stall;
    adv2       = !stall_last;
    en1        = !v1_r || adv2;
    ctl.fire   = v2_r && adv2;
    ctl.eop    = eop2_r;
    ctl.eos    = eos2_r;
  end

  knn3_sqdiff u_sqdiff (
    .query_feature (q1_r),
    .train_feature (t1_r),
    .sq            (sq1)
  );

  knn3_nbr u_nbr (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sq    (sq2_r),
    .cls   (cls2_r),
    .vote  (vote)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (ctl.fire && eos2_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      q1_r   <= in_query_feature;
      t1_r   <= in_train_feature;
      cls1_r <= in_point_class;
      eop1_r <= in_end_of_point;
      eos1_r <= in_end_of_set;
    end
    if (adv2) begin
      sq2_r  <= sq1;
      cls2_r <= cls1_r;
      eop2_r <= eop1_r;
      eos2_r <= eos1_r;
    end
    if (ctl.fire && eos2_r) begin
      out_cls_r   <= vote.cls;
      out_known_r <= vote.known;
    end
  end

  assign in_stall            = !en1;
  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_cls_r;
  assign out_class_known     = out_known_r;

endmodule

// ===== hdl/knn3_checker.sv =====
// ----------------------------------------------------------------------------
// knn3_checker
// Port-level assertions for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module knn3_checker
  import knn3_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [FEATURE_BITS-1:0] in_query_feature,
  input logic signed [FEATURE_BITS-1:0] in_train_feature,
  input logic [CLASS_BITS-1:0]         in_point_class,
  input logic                          in_end_of_point,
  input logic                          in_end_of_set,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [CLASS_BITS-1:0]         out_predicted_class,
  input logic                          out_class_known
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_predicted_class)
                               && $stable(out_class_known))
    else $error("stalled result changed");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_class_known |-> out_predicted_class == '0)
    else $error("unknown vote carries a nonzero class");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result back-pressure");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

endmodule

bind knn3_euclidean_classifier_unit knn3_checker u_knn3_checker (.*);
